// File: hdl/ais_pkg.sv
// shared types and constants of the ascending integer sorter
package ais_pkg;

   // width of one element
   localparam int unsigned DATA_WIDTH = 32;

   // controller states, one-hot
   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic insert;   // insert the incoming element into the sorted row
      logic shift;    // move the head into the result register, shift row down
   } cmd_type;

endpackage

// File: hdl/ais_channels.sv
// valid/ready channel interfaces for the element and result items

interface ais_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ais_pkg::DATA_WIDTH-1:0] value;
   logic                                   last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface ais_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ais_pkg::DATA_WIDTH-1:0] sorted_value;
   logic                                   final_res;
   logic                                   overflow;

   modport source (output valid, output sorted_value, output final_res, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input final_res, input overflow,
                   output ready);
endinterface

// File: hdl/ais_datapath.sv
// row of sorting cells with parallel compare and the result data register
module ais_datapath #(
   parameter int unsigned MAX_ITEMS  = 64,
   parameter int unsigned CountWidth = 7
) (
   input  logic                                   clock,
   input  ais_pkg::cmd_type                       cmd,
   input  logic [CountWidth-1:0]                  count,
   input  logic signed [ais_pkg::DATA_WIDTH-1:0] value,
   output logic signed [ais_pkg::DATA_WIDTH-1:0] sorted_value
);

   logic signed [ais_pkg::DATA_WIDTH-1:0] cell_ff [MAX_ITEMS];
   logic signed [ais_pkg::DATA_WIDTH-1:0] cell_in [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]                  greater;
   logic [MAX_ITEMS-1:0]                  at_end;
   logic signed [ais_pkg::DATA_WIDTH-1:0] sorted_value_ff;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      // occupied cells holding a value above the new one
      assign greater[i] = (count > CountWidth'(i)) && (cell_ff[i] > value);
      assign at_end[i]  = (count == CountWidth'(i));

      // shift down on drain, make room and insert on load
      if (i == 0) begin : g_head
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (cmd.shift) begin
               cell_in[i] = (MAX_ITEMS > 1) ? cell_ff[(i + 1) % MAX_ITEMS] : cell_ff[i];
            end else if (cmd.insert && (greater[i] || at_end[i])) begin
               cell_in[i] = value;
            end
         end
      end else begin : g_body
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (cmd.shift) begin
               if (i < MAX_ITEMS - 1) begin
                  cell_in[i] = cell_ff[(i + 1) % MAX_ITEMS];
               end
            end else if (cmd.insert) begin
               if (greater[i-1]) begin
                  cell_in[i] = cell_ff[i-1];
               end else if (greater[i] || at_end[i]) begin
                  cell_in[i] = value;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // result data register, loaded from the head cell
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         sorted_value_ff <= cell_ff[0];
      end
   end

   assign sorted_value = sorted_value_ff;

endmodule

// File: hdl/ais_controller.sv
// load/drain controller: fill count, drop flag, handshakes and result flags
module ais_controller #(
   parameter int unsigned MAX_ITEMS  = 64,
   parameter int unsigned CountWidth = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_final_res,
   output logic                  rsp_overflow,
   output ais_pkg::cmd_type      cmd,
   output logic [CountWidth-1:0] count
);

   ais_pkg::state_type    state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_final_ff, rsp_final_in;
   logic                  rsp_overflow_ff, rsp_overflow_in;
   logic                  accept;
   logic                  room;
   logic                  out_free;
   logic                  emit;
   logic                  emit_final;

   // handshake decode
   assign req_ready  = (state_ff == ais_pkg::ST_LOAD);
   assign accept     = req_valid && req_ready;
   assign room       = (count_ff < CountWidth'(MAX_ITEMS));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit       = (state_ff == ais_pkg::ST_DRAIN) && out_free;
   assign emit_final = emit && (count_ff == CountWidth'(1));

   assign cmd.insert = accept && room;
   assign cmd.shift  = emit;

   // next state, fill count and drop flag
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ais_pkg::ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + CountWidth'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ais_pkg::ST_DRAIN;
               end
            end
         end
         ais_pkg::ST_DRAIN: begin
            if (emit) begin
               count_in = count_ff - CountWidth'(1);
               if (emit_final) begin
                  state_in   = ais_pkg::ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ais_pkg::ST_LOAD;
         end
      endcase
   end

   // result register flags
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_final_in    = rsp_final_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_final_in    = emit_final;
         rsp_overflow_in = dropped_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ais_pkg::ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_final_ff    <= rsp_final_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_final_res = rsp_final_ff;
   assign rsp_overflow  = rsp_overflow_ff;
   assign count         = count_ff;

   // fill count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MAX_ITEMS))
      else $error("fill count above capacity");

   // draining always has at least one element left
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ais_pkg::ST_DRAIN) |-> (count_ff != '0))
      else $error("drain with empty row");

   // insert and shift never in the same cycle
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.shift))
      else $error("insert and shift together");

   // the final result returns the block to loading with an empty row
   a_final_returns: assert property (@(posedge clock) disable iff (reset)
      emit_final |=> (state_ff == ais_pkg::ST_LOAD) && (count_ff == '0) && !dropped_ff
                     && rsp_valid_ff && rsp_final_ff)
      else $error("final result did not close the set");

   // an element past capacity sets the drop flag that reports overflow on its set's results
   a_drop_marks: assert property (@(posedge clock) disable iff (reset)
      (accept && !room) |=> dropped_ff)
      else $error("dropped element not flagged");

endmodule

// File: hdl/ascending_integer_sorter.sv
// top level of the ascending integer sorter
//
// Usage:
//   req_bus carries one signed 32-bit element per item; last marks the final
//   element of a set. Elements are kept in ascending order as they arrive in a
//   row of MAX_ITEMS compare-and-shift cells, one element accepted per cycle.
//   After the last element the row drains through rsp_bus, one result per
//   cycle from smallest to largest; final_res marks the largest result and
//   overflow is set on every result of a set that lost elements past capacity.
//   After its last element is accepted the controller enters the drain state
//   and moves the head cell into the output register whenever that register is
//   free; the row is shared, so req_bus is not ready while a set
//   drains. The next set may start loading while the final result still waits
//   in the output register.
//   When the receiver stalls, the output register holds its result and the
//   row stops shifting until rsp_bus.ready rises.
//   Reset (synchronous, active high) empties the row, clears the drop flag
//   and the output valid flag; element cells and result data are not cleared.
module ascending_integer_sorter #(
   parameter int unsigned MAX_ITEMS = 64
) (
   input  logic     clock,
   input  logic     reset,
   ais_req_if.sink   req_bus,
   ais_rsp_if.source rsp_bus
);

   localparam int unsigned CountWidth = $clog2(MAX_ITEMS + 1);

   ais_pkg::cmd_type      cmd;
   logic [CountWidth-1:0] count;

   ais_controller #(
      .MAX_ITEMS  (MAX_ITEMS),
      .CountWidth (CountWidth)
   ) u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_last      (req_bus.last),
      .req_ready     (req_bus.ready),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_final_res (rsp_bus.final_res),
      .rsp_overflow  (rsp_bus.overflow),
      .cmd           (cmd),
      .count         (count)
   );

   ais_datapath #(
      .MAX_ITEMS  (MAX_ITEMS),
      .CountWidth (CountWidth)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .count        (count),
      .value        (req_bus.value),
      .sorted_value (rsp_bus.sorted_value)
   );

endmodule

// File: verif/tb_ascending_integer_sorter.sv
// self-checking testbench of the ascending integer sorter
`timescale 1ns / 100ps

module tb_ascending_integer_sorter;

   localparam int SET_CAP       = 64;
   localparam int STALL_LIMIT   = 3000;
   localparam int ITEM_TARGET   = 430;
   localparam int LONG_HOLD_OFF = 300;
   localparam int DRAIN_SLACK   = 10;

   localparam logic signed [ais_pkg::DATA_WIDTH-1:0] MOST_NEG =
      {1'b1, {(ais_pkg::DATA_WIDTH-1){1'b0}}};
   localparam logic signed [ais_pkg::DATA_WIDTH-1:0] MOST_POS =
      {1'b0, {(ais_pkg::DATA_WIDTH-1){1'b1}}};

   // one element to send, with the idle time that follows it
   typedef struct {
      logic signed [ais_pkg::DATA_WIDTH-1:0] value;
      logic                                  last;
      int unsigned                           pause;
      bit                                    wait_drained;
   } elem_item_type;

   // one expected sorted result
   typedef struct {
      logic signed [ais_pkg::DATA_WIDTH-1:0] sorted_value;
      logic                                  final_res;
      logic                                  overflow;
   } sorted_rsp_type;

   typedef enum int {
      VAL_WIDE,
      VAL_NARROW,
      VAL_EDGES,
      VAL_MIXED
   } value_mode_type;

   logic clock;
   logic reset;

   ais_req_if req_bus ();
   ais_rsp_if rsp_bus ();

   ascending_integer_sorter #(
      .MAX_ITEMS (SET_CAP)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   elem_item_type  elem_pending[$];
   sorted_rsp_type sorted_expect[$];

   // predicted contents of the sorting row
   logic signed [ais_pkg::DATA_WIDTH-1:0] held_row[$];
   bit                                    held_dropped;

   int results_due  = 0;
   int results_seen = 0;
   int mismatches   = 0;
   int idle_cycles  = 0;
   int items_queued = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // insert one accepted element; on the last one, queue the set in ascending order
   function automatic void insert_element(input logic signed [ais_pkg::DATA_WIDTH-1:0] v,
                                          input logic last);
      int             pos;
      sorted_rsp_type r;
      if (held_row.size() < SET_CAP) begin
         pos = held_row.size();
         // equal values stay in arrival order
         while (pos > 0 && held_row[pos-1] > v)
            pos--;
         held_row.insert(pos, v);
      end else begin
         held_dropped = 1'b1;
      end
      if (last) begin
         foreach (held_row[k]) begin
            r.sorted_value = held_row[k];
            r.final_res    = (k == held_row.size() - 1);
            r.overflow     = held_dropped;
            sorted_expect.push_back(r);
         end
         results_due += held_row.size();
         held_row.delete();
         held_dropped = 1'b0;
      end
   endfunction

   // mostly no pause, some short ones, a few long
   function automatic int unsigned pick_pause();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 68)
         return 0;
      else if (roll < 92)
         return $urandom_range(3, 1);
      else
         return $urandom_range(40, 6);
   endfunction

   function automatic logic signed [ais_pkg::DATA_WIDTH-1:0] pick_value(
      input value_mode_type mode);
      value_mode_type m;
      m = mode;
      if (m == VAL_MIXED)
         m = value_mode_type'($urandom_range(2));
      case (m)
         VAL_NARROW: begin
            return int'($urandom_range(16)) - 8;
         end
         VAL_EDGES: begin
            case ($urandom_range(5))
               0:       return MOST_NEG;
               1:       return MOST_POS;
               2:       return MOST_NEG + 1;
               3:       return MOST_POS - 1;
               4:       return -1;
               default: return 0;
            endcase
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic add_elem(input logic signed [ais_pkg::DATA_WIDTH-1:0] v, input logic last,
                           input bit wait_drained, input bit calm);
      elem_item_type it;
      it.value        = v;
      it.last         = last;
      it.pause        = calm ? 0 : pick_pause();
      it.wait_drained = wait_drained;
      elem_pending.push_back(it);
      items_queued++;
   endtask

   // a whole set of n random elements, last flag on the final one
   task automatic add_set(input int n, input value_mode_type mode, input bit wait_drained);
      bit calm;
      calm = ($urandom_range(4) == 0);
      for (int i = 0; i < n; i++)
         add_elem(pick_value(mode), i == n - 1, wait_drained && i == 0, calm);
   endtask

   // element driver
   always @(posedge clock) begin : elem_driver
      elem_item_type nxt;
      int unsigned   pause_left;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= '0;
         req_bus.last  <= 1'b0;
         pause_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            insert_element(req_bus.value, req_bus.last);
         if (!req_bus.valid || req_bus.ready) begin
            if (pause_left > 0) begin
               pause_left--;
               req_bus.valid <= 1'b0;
            end else if (elem_pending.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (elem_pending[0].wait_drained && results_seen != results_due) begin
               // hold the next set back until every result is out
               req_bus.valid <= 1'b0;
            end else begin
               nxt = elem_pending.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.value <= nxt.value;
               req_bus.last  <= nxt.last;
               pause_left = nxt.pause;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin : sorted_monitor
      sorted_rsp_type want;
      int hold_left;
      int gap_left;
      int calm_left;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
         gap_left  = 0;
         calm_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen <= results_seen + 1;
            // long hold-off twice, while the sender keeps offering
            if (results_seen + 1 == 150 || results_seen + 1 == 320)
               hold_left = LONG_HOLD_OFF;
            if (sorted_expect.size() == 0) begin
               $display("%0t unexpected result: got value %0d final %0b overflow %0b",
                        $time, rsp_bus.sorted_value, rsp_bus.final_res, rsp_bus.overflow);
               mismatches++;
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_bus.sorted_value !== want.sorted_value) begin
                  $display("%0t sorted_value mismatch: expected %0d, got %0d",
                           $time, want.sorted_value, rsp_bus.sorted_value);
                  mismatches++;
               end
               if (rsp_bus.final_res !== want.final_res) begin
                  $display("%0t final_res mismatch: expected %0b, got %0b",
                           $time, want.final_res, rsp_bus.final_res);
                  mismatches++;
               end
               if (rsp_bus.overflow !== want.overflow) begin
                  $display("%0t overflow mismatch: expected %0b, got %0b",
                           $time, want.overflow, rsp_bus.overflow);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else if ($urandom_range(7) == 0) begin
               gap_left = ($urandom_range(9) == 0) ? $urandom_range(40, 8)
                                                   : $urandom_range(3, 1);
               if ($urandom_range(5) == 0)
                  calm_left = $urandom_range(80, 20);
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t no progress for %0d cycles", $time, idle_cycles);
            $display("tb_ascending_integer_sorter failed");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      req_bus.last  = 1'b0;
      rsp_bus.ready = 1'b0;
      reset         = 1'b1;
      held_dropped  = 1'b0;

      // single-element sets at both extremes
      add_elem(MOST_NEG, 1'b1, 1'b0, 1'b0);
      add_elem(MOST_POS, 1'b1, 1'b0, 1'b0);
      // extremes, zero and a repeated value
      add_elem(MOST_POS,     1'b0, 1'b0, 1'b0);
      add_elem(0,            1'b0, 1'b0, 1'b0);
      add_elem(-1,           1'b0, 1'b0, 1'b0);
      add_elem(MOST_NEG,     1'b0, 1'b0, 1'b0);
      add_elem(1,            1'b0, 1'b0, 1'b0);
      add_elem(-1,           1'b0, 1'b0, 1'b0);
      add_elem(MOST_POS - 1, 1'b1, 1'b0, 1'b0);
      // already ascending
      add_elem(-3, 1'b0, 1'b0, 1'b0);
      add_elem(-2, 1'b0, 1'b0, 1'b0);
      add_elem(5,  1'b0, 1'b0, 1'b0);
      add_elem(9,  1'b1, 1'b0, 1'b0);
      // descending, sent only once the row has drained
      add_elem(100,  1'b0, 1'b1, 1'b0);
      add_elem(50,   1'b0, 1'b0, 1'b0);
      add_elem(-50,  1'b0, 1'b0, 1'b0);
      add_elem(-100, 1'b1, 1'b0, 1'b0);
      // all equal
      add_elem(7, 1'b0, 1'b0, 1'b0);
      add_elem(7, 1'b0, 1'b0, 1'b0);
      add_elem(7, 1'b1, 1'b0, 1'b0);

      // exactly full, then one element too many carried by the last flag
      add_set(SET_CAP, VAL_MIXED, 1'b1);
      add_set(SET_CAP + 1, VAL_WIDE, 1'b0);

      // random sets, mostly short
      while (items_queued < ITEM_TARGET) begin : random_sets
         int unsigned roll;
         int          n;
         roll = $urandom_range(99);
         if (roll < 85)
            n = $urandom_range(10, 1);
         else if (roll < 95)
            n = $urandom_range(SET_CAP - 1, 11);
         else
            n = $urandom_range(SET_CAP + 16, SET_CAP);
         add_set(n, value_mode_type'($urandom_range(3)), $urandom_range(7) == 0);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (elem_pending.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (results_seen != results_due)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);

      if (sorted_expect.size() != 0) begin
         $display("%0t %0d expected results never arrived", $time, sorted_expect.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("tb_ascending_integer_sorter passed");
      else
         $display("tb_ascending_integer_sorter failed");
      $finish;
   end

endmodule
